// ===== hdl/sfe_pkg.sv =====
// Shared types and constants for the saturating feedback echo.
// Depends on nothing; every module of the block imports it.
package sfe_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int GAIN_W    = 16;
  localparam int GAIN_FRAC = 14;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [GAIN_W-1:0]          gain_t;
  typedef logic [15:0]                delay_t;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_ECHO_GAIN     = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DELAY_SAMPLES = 1'd1;

  localparam gain_t  ECHO_GAIN_RESET     = 16'd8192;
  localparam delay_t DELAY_SAMPLES_RESET = 16'd4800;

  localparam logic [15:0] FILL_MAX = 16'hFFFF;

endpackage

// ===== hdl/saturating_feedback_echo.sv =====
// Top level of the saturating feedback echo: control, pointers and the
// pipeline around the delay memory. Uses sfe_pkg, sfe_delay_mem, sfe_mix.
//
//  Channel   Signals                              Moves
//  --------  -----------------------------------  ------------------------
//  input     in_valid, in_ready, sample_in        one sample request
//  output    out_valid, out_ready, sample_out     one echoed sample
//  config    cfg_wr_en, cfg_index, cfg_data       register write, no wait
//
// One request is taken per clock cycle unless the output stalls; the rate is
// set by the delay memory, which serves one read (at request accept) and one
// write (as the result leaves the mix stage) each cycle. An accepted request
// passes the mix stage and then the output register before it is presented.
// Reset clears pointers, fill count and registers; the memory is not cleared,
// because the warm-up rule never reads an entry before it is written.
// A stalled output holds the mix stage and then stops accepting requests.
module saturating_feedback_echo #(
  parameter int DELAY_DEPTH = 65536
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sfe_pkg::sample_t                    sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sfe_pkg::sample_t                    sample_out,
  input  logic                                cfg_wr_en,
  input  logic [sfe_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [15:0]                         cfg_data
);
  import sfe_pkg::*;

  localparam int AW = $clog2(DELAY_DEPTH);
  // Wide enough for the depth itself and for any delay register value.
  localparam int CW = ((AW > 16) ? AW : 16) + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DELAY_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DELAY_DEPTH - 1);

  // Configuration registers.
  gain_t  echo_gain;
  delay_t delay_samples;

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_gain     <= ECHO_GAIN_RESET;
      delay_samples <= DELAY_SAMPLES_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ECHO_GAIN:     echo_gain     <= cfg_data;
        REG_DELAY_SAMPLES: delay_samples <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective delay: zero acts as one, and the delay never exceeds the depth.
  logic [CW-1:0] delay_raw;
  logic [CW-1:0] delay_eff;
  logic [CW-1:0] wp_ext;
  logic [CW-1:0] rd_wide;
  logic [AW-1:0] rd_addr;

  logic [AW-1:0] wp;
  logic [15:0]   fill_count;

  always_comb begin
    delay_raw = CW'(delay_samples);
    if (delay_samples == '0) begin
      delay_eff = CW'(1);
    end else if (delay_raw > DEPTH_C) begin
      delay_eff = DEPTH_C;
    end else begin
      delay_eff = delay_raw;
    end
    wp_ext  = CW'(wp);
    rd_wide = (wp_ext >= delay_eff) ? wp_ext - delay_eff : wp_ext + DEPTH_C - delay_eff;
    rd_addr = rd_wide[AW-1:0];
  end

  // Mix stage: holds an accepted request while its delayed sample is read.
  logic          s1_valid;
  sample_t       s1_x;
  logic          s1_use;
  logic [AW-1:0] s1_addr;
  logic          fwd_sel;
  sample_t       fwd_data;

  sample_t mem_rdata;
  sample_t echo_src;
  sample_t mix_y;

  logic accept;
  logic s1_move;
  logic fwd_hit;

  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_move;
  assign accept   = in_valid && in_ready;

  // When the delay is one sample, the entry to read is the one being written
  // by the request leaving the mix stage at this very edge. The memory would
  // return stale data, so that result is captured and used instead.
  assign fwd_hit  = s1_move && (rd_addr == s1_addr);
  assign echo_src = fwd_sel ? fwd_data : mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= '0;
      fill_count <= '0;
      s1_valid   <= 1'b0;
      fwd_sel    <= 1'b0;
    end else begin
      if (accept) begin
        wp       <= (wp == LAST_ADDR) ? '0 : wp + AW'(1);
        if (fill_count != FILL_MAX) begin
          fill_count <= fill_count + 16'd1;
        end
        s1_valid <= 1'b1;
        fwd_sel  <= fwd_hit;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Payload of the mix stage needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x     <= sample_in;
      s1_use   <= CW'(fill_count) >= delay_eff;
      s1_addr  <= wp;
      fwd_data <= mix_y;
    end
  end

  sfe_delay_mem #(
    .DEPTH (DELAY_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_addr),
    .wdata (mix_y),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  sfe_mix u_mix (
    .x        (s1_x),
    .echo     (echo_src),
    .gain     (echo_gain),
    .use_echo (s1_use),
    .y        (mix_y)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      sample_out <= mix_y;
    end
  end

  // An empty output register must never block a new request.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request refused while output register is empty");

  // Forwarding is only ever needed for a delay of one sample.
  a_fwd_only_delay_one: assert property (@(posedge clk) disable iff (rst)
    (accept && fwd_hit) |-> (delay_eff == CW'(1)))
    else $error("forwarding selected for a delay other than one");

  // A stalled output must keep the mix stage occupied.
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |=> s1_valid)
    else $error("mix stage dropped a request during an output stall");

  // The fill count only grows or saturates.
  a_fill_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (fill_count >= $past(fill_count)))
    else $error("fill count decreased");

endmodule

// ===== hdl/sfe_delay_mem.sv =====
// Delay line storage: one write port, one read port with registered data.
// Depends on sfe_pkg for the sample type.
module sfe_delay_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  sfe_pkg::sample_t  wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output sfe_pkg::sample_t  rdata
);
  import sfe_pkg::*;

  sample_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read during write to the same entry returns the old contents; the
  // caller forwards around that case.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/sfe_mix.sv =====
// Echo arithmetic: scales the delayed sample by the Q2.14 gain, truncates
// toward zero, saturates, and adds the input with saturation; without use_echo the input passes. Uses sfe_pkg.
module sfe_mix (
  input  sfe_pkg::sample_t x,
  input  sfe_pkg::sample_t echo,
  input  sfe_pkg::gain_t   gain,
  input  logic             use_echo,
  output sfe_pkg::sample_t y
);
  import sfe_pkg::*;

  localparam int PW = SAMPLE_W + GAIN_W + 1;
  localparam int QW = PW - GAIN_FRAC;

  logic signed [PW-1:0]       prod;
  logic signed [PW-1:0]       prod_adj;
  logic signed [QW-1:0]       scaled;
  sample_t                    scaled_sat;
  logic signed [SAMPLE_W:0]   sum;
  sample_t                    sum_sat;

  localparam logic signed [QW-1:0] Q_MAX = QW'(32767);
  localparam logic signed [QW-1:0] Q_MIN = -QW'(32768);

  always_comb begin
    prod = PW'(echo) * $signed({1'b0, gain});
    // Biasing a negative product before the arithmetic shift rounds it
    // toward zero instead of toward minus infinity.
    prod_adj = prod[PW-1] ? prod + PW'((1 << GAIN_FRAC) - 1) : prod;
    scaled = QW'(prod_adj >>> GAIN_FRAC);
    if (scaled > Q_MAX) begin
      scaled_sat = 16'sh7FFF;
    end else if (scaled < Q_MIN) begin
      scaled_sat = 16'sh8000;
    end else begin
      scaled_sat = scaled[SAMPLE_W-1:0];
    end
    sum = (SAMPLE_W + 1)'(x) + (SAMPLE_W + 1)'(scaled_sat);
    if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
      sum_sat = sum[SAMPLE_W] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      sum_sat = sum[SAMPLE_W-1:0];
    end
    y = use_echo ? sum_sat : x;
  end

endmodule
